// File: sv/hli_pkg.sv
// Package for the Hough line intersection block.
// Holds widths, the divider beat type and the cos/sin lookup tables.
// No dependencies.
package hli_pkg;

  localparam int ANGLE_BINS     = 180;
  localparam int TRIG_FRAC_BITS = 15;

  localparam int RHO_W  = 13;
  localparam int ANG_W  = 8;
  localparam int OUT_W  = 24;
  localparam int QB     = OUT_W - 1;                // quotient magnitude bits
  localparam int TW     = TRIG_FRAC_BITS + 2;     // trig entry width
  localparam int PW     = 2 * TW;                 // det product width
  localparam int NW     = TW + RHO_W;             // numerator product width
  localparam int DMW    = PW;                     // det magnitude width
  localparam int NMW    = NW;                     // numerator magnitude width
  localparam int CW     = DMW + QB;               // overflow compare width
  localparam int ROM_N  = 1 << ANG_W;

  localparam real PI_R  = 3.14159265358979323846;

  typedef logic signed [TW-1:0] trig_t;
  typedef trig_t trig_rom_t [ROM_N];

  typedef struct packed {
    logic           found;
    logic [DMW-1:0] dmag;
    logic [DMW-1:0] xr;
    logic [QB-1:0]  xq;
    logic           xneg;
    logic           xovf;
    logic [DMW-1:0] yr;
    logic [QB-1:0]  yq;
    logic           yneg;
    logic           yovf;
  } div_t;

  // Reduce to [0, pi/2], round the magnitude, then apply the sign.
  function automatic trig_rom_t build_trig(input bit want_sin);
    trig_rom_t tab;
    int        m;
    bit        nc;
    bit        ns;
    real       ang;
    real       v;
    longint    mag;
    for (int k = 0; k < ROM_N; k++) begin
      m  = k % (2 * ANGLE_BINS);
      nc = 1'b0;
      ns = 1'b0;
      if (m >= ANGLE_BINS) begin
        m  = m - ANGLE_BINS;
        nc = 1'b1;
        ns = 1'b1;
      end
      if (2 * m > ANGLE_BINS) begin
        m  = ANGLE_BINS - m;
        nc = !nc;
      end
      ang = PI_R * m / ANGLE_BINS;
      v   = want_sin ? $sin(ang) : $cos(ang);
      if (v < 0.0) v = 0.0;
      mag = longint'($floor(v * (2.0 ** TRIG_FRAC_BITS) + 0.5));
      if (want_sin ? ns : nc) mag = -mag;
      tab[k] = TW'(mag);
    end
    return tab;
  endfunction

  localparam trig_rom_t COS_TAB = build_trig(1'b0);
  localparam trig_rom_t SIN_TAB = build_trig(1'b1);

endpackage

// File: sv/hli_front.sv
// Front end: trig lookup, products, differences, magnitudes, overflow check.
// Five register stages; depends on hli_pkg.
module hli_front import hli_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic signed [RHO_W-1:0] rho_first_i,
  input  logic [ANG_W-1:0]        angle_first_i,
  input  logic signed [RHO_W-1:0] rho_second_i,
  input  logic [ANG_W-1:0]        angle_second_i,
  output logic                    valid_o,
  output div_t                    data_o
);

  logic [4:0] v_q;

  trig_t c1_q, s1_q, c2_q, s2_q;
  logic signed [RHO_W-1:0] r1_q, r2_q;

  logic signed [PW-1:0] pd1_q, pd2_q;
  logic signed [NW-1:0] px1_q, px2_q, py1_q, py2_q;

  logic signed [PW:0] det_q;
  logic signed [NW:0] nx_q, ny_q;

  logic [DMW-1:0] dmag_q;
  logic [NMW-1:0] xmag_q, ymag_q;
  logic           dneg_q, xneg_q, yneg_q;

  div_t out_d, out_q;

  always_comb begin
    out_d       = '0;
    out_d.found = (dmag_q != '0);
    out_d.dmag  = dmag_q;
    out_d.xr    = DMW'(xmag_q >> QB);
    out_d.xq    = xmag_q[QB-1:0];
    out_d.xneg  = xneg_q ^ dneg_q;
    out_d.xovf  = CW'(xmag_q) >= (CW'(dmag_q) << QB);
    out_d.yr    = DMW'(ymag_q >> QB);
    out_d.yq    = ymag_q[QB-1:0];
    out_d.yneg  = yneg_q ^ dneg_q;
    out_d.yovf  = CW'(ymag_q) >= (CW'(dmag_q) << QB);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c1_q   <= COS_TAB[angle_first_i];
      s1_q   <= SIN_TAB[angle_first_i];
      c2_q   <= COS_TAB[angle_second_i];
      s2_q   <= SIN_TAB[angle_second_i];
      r1_q   <= rho_first_i;
      r2_q   <= rho_second_i;

      pd1_q  <= c1_q * s2_q;
      pd2_q  <= s1_q * c2_q;
      px1_q  <= s2_q * r1_q;
      px2_q  <= s1_q * r2_q;
      py1_q  <= c1_q * r2_q;
      py2_q  <= c2_q * r1_q;

      det_q  <= (PW+1)'(pd1_q) - (PW+1)'(pd2_q);
      nx_q   <= (NW+1)'(px1_q) - (NW+1)'(px2_q);
      ny_q   <= (NW+1)'(py1_q) - (NW+1)'(py2_q);

      dneg_q <= det_q[PW];
      dmag_q <= DMW'(det_q[PW] ? -det_q : det_q);
      xneg_q <= nx_q[NW];
      xmag_q <= NMW'(nx_q[NW] ? -nx_q : nx_q);
      yneg_q <= ny_q[NW];
      ymag_q <= NMW'(ny_q[NW] ? -ny_q : ny_q);

      out_q  <= out_d;
    end
  end

  assign valid_o = v_q[4];
  assign data_o  = out_q;

endmodule

// File: sv/hli_div_cell.sv
// One divider cell: retires one quotient bit for both x and y per beat.
// Depends on hli_pkg.
module hli_div_cell import hli_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  div_t data_i,
  output logic valid_o,
  output div_t data_o
);

  logic        valid_q;
  div_t        data_d, data_q;
  logic [DMW:0] xs, ys;

  always_comb begin
    data_d = data_i;
    xs     = {data_i.xr, data_i.xq[QB-1]};
    ys     = {data_i.yr, data_i.yq[QB-1]};
    data_d.xq = {data_i.xq[QB-2:0], 1'b0};
    data_d.yq = {data_i.yq[QB-2:0], 1'b0};
    // subtract when the shifted remainder covers the divisor
    if (xs >= {1'b0, data_i.dmag}) begin
      xs           = xs - {1'b0, data_i.dmag};
      data_d.xq[0] = 1'b1;
    end
    if (ys >= {1'b0, data_i.dmag}) begin
      ys           = ys - {1'b0, data_i.dmag};
      data_d.yq[0] = 1'b1;
    end
    data_d.xr = xs[DMW-1:0];
    data_d.yr = ys[DMW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

  a_xrem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && data_o.found && !data_o.xovf |-> data_o.xr < data_o.dmag)
    else $error("x remainder not below divisor");
  a_yrem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && data_o.found && !data_o.yovf |-> data_o.yr < data_o.dmag)
    else $error("y remainder not below divisor");
  a_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && valid_i |=> valid_o)
    else $error("beat lost in divider cell");

endmodule

// File: sv/hough_line_intersection.sv
// Hough line intersection: one pair per cycle while not stalled. Five front
// stages (trig lookup, products, differences, magnitudes, overflow check), a
// row of 23 divider cells, one output register. A stall while a result is held
// freezes the whole pipe. Reset clears all valid bits.
// Depends on hli_pkg, hli_front and hli_div_cell.
module hough_line_intersection import hli_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    stall_o,
  input  logic signed [RHO_W-1:0] rho_first_i,
  input  logic [ANG_W-1:0]        angle_first_i,
  input  logic signed [RHO_W-1:0] rho_second_i,
  input  logic [ANG_W-1:0]        angle_second_i,
  output logic                    valid_o,
  input  logic                    stall_i,
  output logic signed [OUT_W-1:0] cross_x_o,
  output logic signed [OUT_W-1:0] cross_y_o,
  output logic                    found_o
);

  logic en;
  logic vld [QB+1];
  div_t dat [QB+1];

  logic                    out_valid_q;
  logic signed [OUT_W-1:0] x_d, x_q, y_d, y_q;
  logic                    found_q;

  // advance whenever the output register is free or being drained
  assign en      = !out_valid_q || !stall_i;
  assign stall_o = !en;

  hli_front u_front (
    .clk_i,
    .rst_ni,
    .en_i           (en),
    .valid_i,
    .rho_first_i,
    .angle_first_i,
    .rho_second_i,
    .angle_second_i,
    .valid_o        (vld[0]),
    .data_o         (dat[0])
  );

  for (genvar g = 0; g < QB; g++) begin : g_cell
    hli_div_cell u_cell (
      .clk_i,
      .rst_ni,
      .en_i    (en),
      .valid_i (vld[g]),
      .data_i  (dat[g]),
      .valid_o (vld[g+1]),
      .data_o  (dat[g+1])
    );
  end

  always_comb begin
    x_d = '0;
    y_d = '0;
    if (dat[QB].found) begin
      if (dat[QB].xovf) x_d = dat[QB].xneg ? {1'b1, {QB{1'b0}}} : {1'b0, {QB{1'b1}}};
      else              x_d = dat[QB].xneg ? -{1'b0, dat[QB].xq} : {1'b0, dat[QB].xq};
      if (dat[QB].yovf) y_d = dat[QB].yneg ? {1'b1, {QB{1'b0}}} : {1'b0, {QB{1'b1}}};
      else              y_d = dat[QB].yneg ? -{1'b0, dat[QB].yq} : {1'b0, dat[QB].yq};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vld[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q     <= x_d;
      y_q     <= y_d;
      found_q <= dat[QB].found;
    end
  end

  assign valid_o   = out_valid_q;
  assign cross_x_o = x_q;
  assign cross_y_o = y_q;
  assign found_o   = found_q;

  a_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !found_o |-> cross_x_o == '0 && cross_y_o == '0)
    else $error("nonzero result without intersection");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |-> stall_o)
    else $error("pipe advanced over a held result");

endmodule

// File: sim/tb_hough_line_intersection.sv
// Testbench for hough_line_intersection: random and directed line pairs with
// random idling on both channels, scored against an in-bench predictor.
// Depends on hli_pkg and the hough_line_intersection RTL.
module tb_hough_line_intersection import hli_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic                    found;
  } cross_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    valid_i;
  logic                    stall_o;
  logic signed [RHO_W-1:0] rho_first_i;
  logic [ANG_W-1:0]        angle_first_i;
  logic signed [RHO_W-1:0] rho_second_i;
  logic [ANG_W-1:0]        angle_second_i;
  logic                    valid_o;
  logic                    stall_i;
  logic signed [OUT_W-1:0] cross_x_o;
  logic signed [OUT_W-1:0] cross_y_o;
  logic                    found_o;

  cross_t pending_cross[$];
  longint cos_lut[ROM_N];
  longint sin_lut[ROM_N];
  bit     tx_idle;
  bit     rx_idle;
  int     rx_hold_cycles;
  int     err_count;

  hough_line_intersection uut (.*);

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("Some tests failed");
    $finish;
  end

  // Fold the bin into [0, pi/2], round the magnitude, then restore signs.
  function automatic void fill_trig_lut();
    int     m;
    bit     neg_c;
    bit     neg_s;
    real    ang;
    real    cv;
    real    sv;
    longint cm;
    longint sm;
    for (int k = 0; k < ROM_N; k++) begin
      m = k % (2 * ANGLE_BINS);
      neg_c = 1'b0;
      neg_s = 1'b0;
      if (m >= ANGLE_BINS) begin
        m = m - ANGLE_BINS;
        neg_c = 1'b1;
        neg_s = 1'b1;
      end
      if (2 * m > ANGLE_BINS) begin
        m = ANGLE_BINS - m;
        neg_c = !neg_c;
      end
      ang = 3.14159265358979323846 * m / ANGLE_BINS;
      cv = $cos(ang);
      sv = $sin(ang);
      if (cv < 0.0) cv = 0.0;
      if (sv < 0.0) sv = 0.0;
      cm = longint'($floor(cv * (2.0 ** TRIG_FRAC_BITS) + 0.5));
      sm = longint'($floor(sv * (2.0 ** TRIG_FRAC_BITS) + 0.5));
      cos_lut[k] = neg_c ? -cm : cm;
      sin_lut[k] = neg_s ? -sm : sm;
    end
  endfunction

  function automatic longint clamp_coord(longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  function automatic cross_t intersect_lines(logic signed [RHO_W-1:0] r1,
                                             logic [ANG_W-1:0] a1,
                                             logic signed [RHO_W-1:0] r2,
                                             logic [ANG_W-1:0] a2);
    cross_t res;
    longint det;
    det = cos_lut[a1] * sin_lut[a2] - sin_lut[a1] * cos_lut[a2];
    res.found = (det != 0);
    res.x = '0;
    res.y = '0;
    if (det != 0) begin
      res.x = OUT_W'(clamp_coord((sin_lut[a2] * r1 - sin_lut[a1] * r2) / det));
      res.y = OUT_W'(clamp_coord((cos_lut[a1] * r2 - cos_lut[a2] * r1) / det));
    end
    return res;
  endfunction

  task automatic send_pair(logic signed [RHO_W-1:0] r1, logic [ANG_W-1:0] a1,
                           logic signed [RHO_W-1:0] r2, logic [ANG_W-1:0] a2);
    int gap;
    gap = tx_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i        <= 1'b1;
    rho_first_i    <= r1;
    angle_first_i  <= a1;
    rho_second_i   <= r2;
    angle_second_i <= a2;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    pending_cross.push_back(intersect_lines(r1, a1, r2, a2));
  endtask

  task automatic stop_sending();
    valid_i <= 1'b0;
  endtask

  task automatic drain_results();
    stop_sending();
    wait (pending_cross.size() == 0);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic logic [ANG_W-1:0] pick_angle();
    return ($urandom_range(0, 7) == 0) ? ANG_W'($urandom_range(180, 255))
                                       : ANG_W'($urandom_range(0, 179));
  endfunction

  task automatic send_random_pair();
    logic [ANG_W-1:0] a1;
    logic [ANG_W-1:0] a2;
    a1 = pick_angle();
    case ($urandom_range(0, 9))
      0: a2 = a1;
      1: a2 = a1 + ANG_W'(ANGLE_BINS);
      2: a2 = a1 + 8'd1;
      default: a2 = pick_angle();
    endcase
    send_pair(RHO_W'($urandom_range(0, 8191)), a1, RHO_W'($urandom_range(0, 8191)), a2);
  endtask

  task automatic test_directed();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    send_pair(13'sd0, 8'd0, 13'sd0, 8'd90);
    send_pair(13'sd4095, 8'd0, 13'sd4095, 8'd90);
    send_pair(-13'sd4096, 8'd0, -13'sd4096, 8'd90);
    send_pair(13'sd4095, 8'd0, -13'sd4096, 8'd1);
    send_pair(-13'sd4096, 8'd179, 13'sd4095, 8'd0);
    send_pair(13'sd100, 8'd45, 13'sd200, 8'd135);
    send_pair(13'sd4095, 8'd60, 13'sd4095, 8'd60);       // parallel, same bin
    send_pair(13'sd12, 8'd30, -13'sd7, 8'd210);          // parallel, bins a half turn apart
    send_pair(13'sd300, 8'd255, 13'sd50, 8'd10);         // bin past the 180 angle bins
    send_pair(-13'sd1, 8'd180, 13'sd1, 8'd90);
    send_pair(13'sd2048, 8'd89, -13'sd2048, 8'd91);
    send_pair(13'sd1, 8'd170, 13'sd4095, 8'd5);
    send_pair(-13'sd4096, 8'd255, -13'sd4096, 8'd254);
    send_pair(13'sd4095, 8'd128, 13'sd2730, 8'd64);
    drain_results();
  endtask

  task automatic test_random(int n);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (i % 300 == 150) begin
        tx_idle = 1'b0;
        rx_idle = 1'b0;
      end else if (i % 300 == 0) begin
        tx_idle = 1'b1;
        rx_idle = 1'b1;
      end
      send_random_pair();
    end
    drain_results();
  endtask

  task automatic test_backpressure();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    rx_hold_cycles = 200;
    for (int i = 0; i < 80; i++) send_random_pair();
    stop_sending();
    wait (pending_cross.size() == 0);   // sender pauses until the pipe empties
    rx_idle = 1'b1;
    for (int i = 0; i < 40; i++) send_random_pair();
    drain_results();
  endtask

  // Result side: stall before each beat for a random wait, or a long hold.
  initial begin
    int w;
    stall_i = 1'b1;
    @(posedge rst_ni);
    forever begin
      if (rx_hold_cycles > 0) begin
        stall_i <= 1'b1;
        repeat (rx_hold_cycles) @(posedge clk_i);
        rx_hold_cycles = 0;
      end
      w = rx_idle ? $urandom_range(0, 15) : 0;
      if (w > 0) begin
        stall_i <= 1'b1;
        repeat (w) @(posedge clk_i);
      end
      stall_i <= 1'b0;
      do @(posedge clk_i); while (!valid_o && rx_hold_cycles == 0);
    end
  end

  always @(posedge clk_i) begin
    cross_t want;
    if (rst_ni && valid_o && !stall_i) begin
      if (pending_cross.size() == 0) begin
        $error("result beat with nothing expected");
        err_count++;
      end else begin
        want = pending_cross.pop_front();
        if (cross_x_o !== want.x) begin
          $error("cross_x expected %0d got %0d", want.x, cross_x_o);
          err_count++;
        end
        if (cross_y_o !== want.y) begin
          $error("cross_y expected %0d got %0d", want.y, cross_y_o);
          err_count++;
        end
        if (found_o !== want.found) begin
          $error("found expected %0b got %0b", want.found, found_o);
          err_count++;
        end
      end
    end
  end

  initial begin
    err_count      = 0;
    tx_idle        = 1'b0;
    rx_idle        = 1'b0;
    rx_hold_cycles = 0;
    rst_ni         = 1'b0;
    valid_i        = 1'b0;
    rho_first_i    = '0;
    angle_first_i  = '0;
    rho_second_i   = '0;
    angle_second_i = '0;
    fill_trig_lut();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random(1100);
    if (err_count == 0 && pending_cross.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
